### design/ica_pkg.sv
// Shared constants and the arctangent table for the attitude unit.
package ica_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CW           = 40;   // CORDIC x/y datapath width
    localparam int STEP_W       = 5;

    localparam logic [1:0] REG_BLEND_WEIGHT = 2'd0;
    localparam logic [1:0] REG_RATE_GAIN    = 2'd1;

    function automatic logic [31:0] atan_lookup(input logic [STEP_W-1:0] idx);
        logic [31:0] r;
        begin
            unique case (idx)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

### design/imu_complementary_attitude_unit.sv
// Top level of the complementary-filter IMU attitude unit.
// One sample request at a time. On acceptance the unit registers the six
// counts and the accelerometer y/z square sum, then runs a 24-step
// bit-serial root alongside a 16-step CORDIC for roll, then a second
// 16-step CORDIC for pitch, and blends roll and pitch through one shared
// signed multiplier over a short sequence (predict, error, scale, correct,
// once per axis). m_valid rises once the root, the pitch CORDIC and the
// 8-step blend are through; a zero pitch vector skips the pitch pass.
// s_ready is low from acceptance until the result request is taken on the
// m_ side. Yaw is pure gyro integration. Configuration writes (index 0
// blend_weight, 1 rate_gain) take effect at once and belong only in cycles
// with no request in flight; other indexes are ignored.
module imu_complementary_attitude_unit import ica_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    input  logic signed [15:0] s_rate_x,
    input  logic signed [15:0] s_rate_y,
    input  logic signed [15:0] s_rate_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_roll_angle,
    output logic signed [15:0] m_pitch_angle,
    output logic signed [15:0] m_yaw_angle
);
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_SQ    = 10'b0000000010,
        ST_RUN   = 10'b0000000100,
        ST_PITCH = 10'b0000001000,
        ST_PRED  = 10'b0000010000,
        ST_ERR   = 10'b0000100000,
        ST_CORR  = 10'b0001000000,
        ST_NEXT  = 10'b0010000000,
        ST_OUT   = 10'b0100000000,
        ST_MUL   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [16:0] blend_weight_reg;
    logic [15:0] rate_gain_reg;
    logic [31:0] roll_acc_reg, pitch_acc_reg, yaw_acc_reg;

    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic [32:0] sq_reg;
    logic [31:0] roll_ref_reg, pitch_ref_reg;
    logic        roll_ok_reg, root_ok_reg;
    logic [23:0] root_reg;
    logic        sel_reg;     // 0 = roll, 1 = pitch
    logic [31:0] pred_reg;
    logic [31:0] err_reg;
    logic [48:0] prod_reg;

    logic        sq_start, cd_start, cd_done, rt_done;
    logic [CW-1:0] cd_y, cd_x;
    logic [31:0] cd_angle;
    logic [23:0] rt_root;

    // shared multiplier: signed 33 x 18 (gain or beta operand)
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;
    logic [16:0] alpha_sat;
    logic [16:0] beta;
    logic [31:0] acc_sel, ref_sel;
    logic signed [15:0] rate_sel;

    assign alpha_sat = (blend_weight_reg > 17'd65536) ? 17'd65536 : blend_weight_reg;
    assign beta      = 17'd65536 - alpha_sat;
    assign acc_sel   = sel_reg ? pitch_acc_reg : roll_acc_reg;
    assign ref_sel   = sel_reg ? pitch_ref_reg : roll_ref_reg;
    assign rate_sel  = sel_reg ? gy_reg : gx_reg;

    always_comb begin
        if (state_reg == ST_MUL) begin
            mul_a = $signed({err_reg[31], err_reg});
            mul_b = $signed({1'b0, beta});
        end else begin
            mul_a = 33'(rate_sel);
            mul_b = $signed({2'b00, rate_gain_reg});
        end
    end
    assign mul_p = mul_a * mul_b;

    assign sq_start = (state_reg == ST_SQ);
    assign cd_start = sq_start || (state_reg == ST_PITCH);
    assign cd_y = (state_reg == ST_PITCH) ? CW'(-(34'(ax_reg)) <<< 8)
                                         : CW'(ay_reg) <<< 16;
    assign cd_x = (state_reg == ST_PITCH) ? CW'({1'b0, root_reg})
                                         : CW'(az_reg) <<< 16;

    ica_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cd_start),
        .y_in(cd_y), .x_in(cd_x), .done(cd_done), .angle(cd_angle)
    );

    ica_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .radicand({sq_reg[31:0], 16'd0}), .done(rt_done), .root(rt_root)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_SQ;
            ST_SQ:    state_next = ST_RUN;
            ST_RUN:   if ((roll_ok_reg || cd_done) && (root_ok_reg || rt_done))
                          state_next = ST_PITCH;
            ST_PITCH: state_next = ST_NEXT;
            ST_NEXT:  if (cd_done) state_next = ST_PRED;
            ST_PRED:  state_next = ST_ERR;
            ST_ERR:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_CORR;
            ST_CORR:  state_next = sel_reg ? ST_OUT : ST_PRED;
            ST_OUT:   if (m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            blend_weight_reg <= 17'd64225;
            rate_gain_reg    <= 16'd1455;
            roll_acc_reg     <= '0;
            pitch_acc_reg    <= '0;
            yaw_acc_reg      <= '0;
            roll_ok_reg      <= 1'b0;
            root_ok_reg      <= 1'b0;
            sel_reg          <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_index == REG_BLEND_WEIGHT) blend_weight_reg <= cfg_data;
                else if (cfg_index == REG_RATE_GAIN) rate_gain_reg <= cfg_data[15:0];
            end
            unique case (state_reg)
                ST_SQ: begin
                    roll_ok_reg <= 1'b0;
                    root_ok_reg <= 1'b0;
                    sel_reg     <= 1'b0;
                end
                ST_RUN: begin
                    if (cd_done) roll_ok_reg <= 1'b1;
                    if (rt_done) root_ok_reg <= 1'b1;
                end
                ST_CORR: begin
                    // rounded correction, floor((err*beta + 2^15) / 2^16)
                    if (sel_reg) pitch_acc_reg <= pred_reg + 32'(prod_reg[48:16]);
                    else         roll_acc_reg  <= pred_reg + 32'(prod_reg[48:16]);
                    sel_reg <= 1'b1;
                    if (sel_reg)
                        yaw_acc_reg <= yaw_acc_reg + 32'(33'(gz_reg) * $signed({1'b0, rate_gain_reg}));
                end
                default: ;
            endcase
        end
        if (state_reg == ST_IDLE && s_valid) begin
            ax_reg <= s_accel_x; ay_reg <= s_accel_y; az_reg <= s_accel_z;
            gx_reg <= s_rate_x;  gy_reg <= s_rate_y;  gz_reg <= s_rate_z;
        end
        // square sum taken straight from the request so the root starts on it
        if (state_reg == ST_IDLE)
            sq_reg <= 33'(32'(s_accel_y) * 32'(s_accel_y))
                    + 33'(32'(s_accel_z) * 32'(s_accel_z));
        if (state_reg == ST_RUN && rt_done) root_reg <= rt_root;
        if (state_reg == ST_RUN && cd_done) roll_ref_reg <= cd_angle;
        if (state_reg == ST_NEXT && cd_done) pitch_ref_reg <= cd_angle;
        if (state_reg == ST_PRED) pred_reg <= acc_sel + mul_p[31:0];
        if (state_reg == ST_ERR)  err_reg  <= ref_sel - pred_reg;
        if (state_reg == ST_MUL)  prod_reg <= 49'(mul_p) + 49'd32768;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT);
    assign m_roll_angle  = roll_acc_reg[31:16];
    assign m_pitch_angle = pitch_acc_reg[31:16];
    assign m_yaw_angle   = yaw_acc_reg[31:16];
endmodule

### design/ica_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
module ica_sqrt import ica_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] radicand,
    output logic        done,
    output logic [23:0] root
);
    logic [47:0] rem_reg, rem_next;
    logic [47:0] rad_reg, rad_next;
    logic [23:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [49:0] trial;
    logic [49:0] shifted;

    always_comb begin
        rem_next  = rem_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, rad_reg[47:46]};
        trial     = shifted - {24'd0, root_reg, 2'b01};
        if (start) begin
            rem_next  = '0;
            rad_next  = radicand;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[45:0], 2'b00};
            if (!trial[49]) begin
                rem_next  = trial[47:0];
                root_next = {root_reg[22:0], 1'b1};
            end else begin
                rem_next  = shifted[47:0];
                root_next = {root_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

### design/ica_cordic.sv
// Iterative CORDIC vectoring unit: atan2(y, x) as a 32-bit binary angle.
module ica_cordic import ica_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [CW-1:0] y_in,
    input  logic [CW-1:0] x_in,
    output logic          done,
    output logic [31:0]   angle
);
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic [31:0]          z_reg, z_next;
    logic [STEP_W-1:0]    i_reg, i_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic signed [CW-1:0] xs, ys, xi, yi;

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        xi        = $signed(x_in);
        yi        = $signed(y_in);
        xs        = x_reg >>> i_reg;
        ys        = y_reg >>> i_reg;
        if (start) begin
            i_next = '0;
            if (xi == '0 && yi == '0) begin
                x_next = '0; y_next = '0; z_next = '0;
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
                if (xi < 0) begin
                    x_next = -xi; y_next = -yi; z_next = 32'h80000000;
                end else begin
                    x_next = xi; y_next = yi; z_next = '0;
                end
            end
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_lookup(i_reg);
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_lookup(i_reg);
            end
            i_next = i_reg + 1'b1;
            if (i_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign angle = z_reg;
endmodule

### verif/tb_imu_complementary_attitude_unit.sv
// Self-checking regression bench for the complementary-filter IMU attitude unit.
`timescale 1ns / 100ps

module tb_imu_complementary_attitude_unit;
    import ica_pkg::*;

    // Spare index codes: the unit must ignore writes to them
    localparam logic [1:0] REG_SPARE_2 = 2'd2;
    localparam logic [1:0] REG_SPARE_3 = 2'd3;

    // Longest run of cycles with no request moving on either side
    localparam int IDLE_LIMIT  = 5000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 60;

    // Our own arctangent table, atan(2^-i) scaled to a 2^32 full circle
    localparam logic [31:0] ARCTAN_STEP [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct {
        logic signed [15:0] ax, ay, az, gx, gy, gz;
    } imu_sample_t;

    typedef struct {
        logic signed [15:0] roll, pitch, yaw;
    } attitude_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [16:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_accel_x, s_accel_y, s_accel_z;
    logic signed [15:0] s_rate_x, s_rate_y, s_rate_z;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_roll_angle, m_pitch_angle, m_yaw_angle;

    imu_complementary_attitude_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_accel_x     (s_accel_x),
        .s_accel_y     (s_accel_y),
        .s_accel_z     (s_accel_z),
        .s_rate_x      (s_rate_x),
        .s_rate_y      (s_rate_y),
        .s_rate_z      (s_rate_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_roll_angle  (m_roll_angle),
        .m_pitch_angle (m_pitch_angle),
        .m_yaw_angle   (m_yaw_angle)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Shadow copy of the unit's registers and angle accumulators
    logic [16:0] shadow_weight;
    logic [15:0] shadow_gain;
    logic [31:0] roll_accum, pitch_accum, yaw_accum;

    attitude_t attitude_q[$];
    int        mismatches;
    int        idle_cycles;
    bit        quiet;          // no idling on either side in the closing part
    bit        hold_request;   // asks the receiver for one long hold-off
    int        hold_left;
    int        stall_left;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // floor(sqrt(n)), bit-pair method
    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // CORDIC vectoring atan2(y, x) as a 32-bit binary angle; >>> floors
    function automatic logic [31:0] vector_angle(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 32'd0;   // zero vector reads as angle zero
        if (x < 0) begin                      // left half plane: turn by half a circle
            x = -x;
            y = -y;
            z = 64'sh80000000;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ARCTAN_STEP[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ARCTAN_STEP[i]);
            end
        end
        return z[31:0];
    endfunction

    function automatic logic [31:0] filter_angle(logic [31:0] accum, longint rate,
                                                 logic [31:0] accel_ref);
        longint      alpha, beta, err, corr;
        logic [31:0] pred, diff;
        longint      step;
        alpha = (shadow_weight > 17'd65536) ? 65536 : longint'(shadow_weight);
        beta  = 65536 - alpha;
        step  = rate * longint'(shadow_gain);
        pred  = accum + step[31:0];
        diff  = accel_ref - pred;
        err   = longint'(signed'(diff));
        corr  = (err * beta + 32768) >>> 16;
        return pred + corr[31:0];
    endfunction

    task automatic predict_attitude(input imu_sample_t s);
        longint          ax, ay, az, gz, yaw_step;
        longint unsigned mag_sq;
        longint          root;
        logic [31:0]     roll_ref, pitch_ref;
        attitude_t       a;
        ax = s.ax; ay = s.ay; az = s.az; gz = s.gz;
        mag_sq    = longint'(ay * ay + az * az);
        root      = longint'(floor_root(mag_sq << 16));
        roll_ref  = vector_angle(ay * 65536, az * 65536);
        pitch_ref = vector_angle(-ax * 256, root);
        roll_accum  = filter_angle(roll_accum, longint'(s.gx), roll_ref);
        pitch_accum = filter_angle(pitch_accum, longint'(s.gy), pitch_ref);
        yaw_step    = gz * longint'(shadow_gain);
        yaw_accum   = yaw_accum + yaw_step[31:0];
        a.roll  = roll_accum[31:16];
        a.pitch = pitch_accum[31:16];
        a.yaw   = yaw_accum[31:16];
        attitude_q.push_back(a);
    endtask

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------

    // Offer one sample; returns at the edge where it was taken
    task automatic send_sample(input imu_sample_t s);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_accel_x <= s.ax;
        s_accel_y <= s.ay;
        s_accel_z <= s.az;
        s_rate_x  <= s.gx;
        s_rate_y  <= s.gy;
        s_rate_z  <= s.gz;
        do @(posedge aclk); while (!s_ready);
        predict_attitude(s);
    endtask

    // Stop offering and wait until every expected attitude has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (attitude_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_BLEND_WEIGHT) shadow_weight = value;
        else if (idx == REG_RATE_GAIN) shadow_gain = value[15:0];
    endtask

    function automatic imu_sample_t make_sample(int ax, int ay, int az,
                                                int gx, int gy, int gz);
        imu_sample_t s;
        s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
        s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
        return s;
    endfunction

    // Full-range noise, or a plausible near-gravity sample with small rates
    function automatic imu_sample_t random_sample(bit plausible);
        imu_sample_t s;
        if (plausible) begin
            s.ax = 16'($urandom_range(0, 40000) - 20000);
            s.ay = 16'($urandom_range(0, 40000) - 20000);
            s.az = 16'($urandom_range(0, 40000) - 20000);
            s.gx = 16'($urandom_range(0, 2000) - 1000);
            s.gy = 16'($urandom_range(0, 2000) - 1000);
            s.gz = 16'($urandom_range(0, 2000) - 1000);
        end else begin
            s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
            s.gx = 16'($urandom); s.gy = 16'($urandom); s.gz = 16'($urandom);
        end
        return s;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Extremes, zero vectors, left half plane, all under reset settings
    task automatic test_directed();
        send_sample(make_sample(0, 0, 0, 0, 0, 0));
        send_sample(make_sample(1000, 0, 0, 5, -5, 7));          // roll ref zero
        send_sample(make_sample(-32768, 0, 0, 0, 0, 0));         // pitch toward top
        send_sample(make_sample(0, 0, 16384, 0, 0, 0));
        send_sample(make_sample(0, 100, -16384, 0, 0, 0));       // negative z: left plane
        send_sample(make_sample(0, -100, -16384, 0, 0, 0));
        send_sample(make_sample(0, 0, -32768, 0, 0, 0));
        send_sample(make_sample(0, 32767, 0, 0, 0, 0));
        send_sample(make_sample(0, -32768, 0, 0, 0, 0));
        send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
        send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
        send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
        send_sample(make_sample(32767, -32768, 32767, -1, 1, -32768));
        send_sample(make_sample(-1, -1, -1, -1, -1, -1));
        send_sample(make_sample(1, 1, 1, 1, 1, 1));
        send_sample(make_sample(-32768, 0, -32768, 12345, -23456, 30000));
    endtask

    // Register extremes, saturated weight and ignored indexes
    task automatic test_config_sweep();
        logic [16:0] weights[5] = '{17'd0, 17'd65536, 17'd131071, 17'd65537, 17'd32768};
        logic [15:0] gains[5]   = '{16'd0, 16'd65535, 16'd1, 16'd1455, 16'd40000};
        foreach (weights[i]) begin
            write_reg(REG_BLEND_WEIGHT, weights[i]);
            write_reg(REG_RATE_GAIN, {1'b0, gains[i]});
            repeat (12) send_sample(random_sample(1'($urandom_range(0, 1))));
        end
        write_reg(REG_SPARE_2, 17'h1FFFF);
        write_reg(REG_SPARE_3, 17'h00000);
        repeat (12) send_sample(random_sample(1'b0));
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 149) begin
                write_reg(REG_BLEND_WEIGHT, 17'($urandom_range(0, 131071)));
                write_reg(REG_RATE_GAIN, 17'($urandom_range(0, 65535)));
            end
            send_sample(random_sample($urandom_range(0, 3) != 0));
        end
    endtask

    // Receiver holds off long while we keep offering, then the sender waits
    // for the unit to empty before going on
    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (20) send_sample(random_sample(1'b1));
        drain_results();
        repeat (20) send_sample(random_sample(1'b0));
    endtask

    // ---------------------------------------------------------------
    // Receiver side: random stalls plus one long hold on request
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            hold_left  <= 0;
            stall_left <= 0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left  <= LONG_HOLD;
            m_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            m_ready    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_ready    <= 1'b0;
        end else begin
            m_ready    <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Result checker and watchdog
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        attitude_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("imu_complementary_attitude_unit regression: fail");
                $finish;
            end
            if (m_valid && m_ready) begin
                if (attitude_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result: roll %0d pitch %0d yaw %0d",
                                 m_roll_angle, m_pitch_angle, m_yaw_angle);
                end else begin
                    want = attitude_q.pop_front();
                    if (m_roll_angle !== want.roll || m_pitch_angle !== want.pitch
                        || m_yaw_angle !== want.yaw) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: exp r/p/y %0d %0d %0d got %0d %0d %0d",
                                     want.roll, want.pitch, want.yaw,
                                     m_roll_angle, m_pitch_angle, m_yaw_angle);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        mismatches    = 0;
        idle_cycles   = 0;
        quiet         = 1'b0;
        hold_request  = 1'b0;
        shadow_weight = 17'd64225;
        shadow_gain   = 16'd1455;
        roll_accum    = '0;
        pitch_accum   = '0;
        yaw_accum     = '0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_accel_x <= '0;
        s_accel_y <= '0;
        s_accel_z <= '0;
        s_rate_x  <= '0;
        s_rate_y  <= '0;
        s_rate_z  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random(900);
        write_reg(REG_BLEND_WEIGHT, 17'd64225);
        write_reg(REG_RATE_GAIN, 17'd1455);
        quiet = 1'b1;               // closing stretch runs back to back
        test_random(200);

        s_valid <= 1'b0;
        while (attitude_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0)
            $display("imu_complementary_attitude_unit regression: pass");
        else
            $display("imu_complementary_attitude_unit regression: fail");
        $finish;
    end

endmodule
